// ===== design/vsi_pkg.sv =====
// Shared widths, constants, controller/datapath handshake structs and helper
// functions for the vector stroke interpolator.
// No dependencies; imported by every other design file.
package vsi_pkg;

  localparam int MAX_SEGMENTS = 8;
  localparam int STEP_SQ      = 25;
  localparam int LEVEL_MAX    = 255;

  localparam int COORD_W = 11;                          // input coordinate width
  localparam int Q_W     = COORD_W + 1;                 // differences and walk positions
  localparam int MAG_W   = COORD_W;                     // magnitude of a difference
  localparam int D2_W    = 2 * MAG_W + 1;               // squared distance
  localparam int SEG_W   = $clog2(MAX_SEGMENTS + 1);    // segment count and point index
  localparam int DCNT_W  = $clog2(MAG_W);               // divider bit counter
  localparam int LEVEL_W = 8;
  localparam int CFG_W   = 1;                           // widest register
  localparam int CIDX_W  = 1;                           // register index

  localparam logic [CIDX_W-1:0] REG_INV_H = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_INV_V = CIDX_W'(1);

  typedef struct packed {
    logic accept;
    logic diff;
    logic square;
    logic segs;
    logic div_step;
    logic fixup;
    logic emit;
  } vsi_cmd_t;

  typedef struct packed {
    logic draw;       // the offered item continues a pen-down stroke
    logic div_last;   // final quotient bit is produced this cycle
    logic emit_last;  // the point on show is the last one of the item
    logic out_free;   // the output register can take a point this cycle
  } vsi_status_t;

  // Largest k in 1..MAX_SEGMENTS with STEP_SQ*k*k <= d2, or 1 if there is none.
  function automatic logic [SEG_W-1:0] seg_count(input logic [D2_W-1:0] d2);
    logic [SEG_W-1:0] s;
    s = SEG_W'(1);
    for (int k = 2; k <= MAX_SEGMENTS; k++) begin
      if (D2_W'(STEP_SQ * k * k) <= d2) s = SEG_W'(k);
    end
    return s;
  endfunction

  // Clamp to the DAC range, then optionally mirror.
  function automatic logic [LEVEL_W-1:0] to_level(input logic signed [Q_W-1:0] v,
                                                  input logic inv);
    logic [LEVEL_W-1:0] c;
    if (v < 0) c = '0;
    else if (v > $signed(Q_W'(LEVEL_MAX))) c = LEVEL_W'(LEVEL_MAX);
    else c = v[LEVEL_W-1:0];
    return inv ? ~c : c;
  endfunction

endpackage

// ===== design/vsi_ctrl.sv =====
// Sequencing state machine of the vector stroke interpolator.
// Depends on vsi_pkg; drives the command struct of vsi_datapath.
module vsi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  vsi_pkg::vsi_status_t st,
  output vsi_pkg::vsi_cmd_t    cmd
);
  import vsi_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIFF   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_SEGS   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FIXUP  = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = st.draw ? ST_DIFF : ST_EMIT;
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_SEGS;
      end
      ST_SEGS: begin
        cmd.segs   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = ST_FIXUP;
      end
      ST_FIXUP: begin
        cmd.fixup  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.emit_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A point is only pushed when the output register has room for it.
  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free) else $error("point emitted into a full output register");

  // The last point of an item always returns the controller to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && st.emit_last) |=> (state == ST_IDLE))
    else $error("controller did not return to idle after the last point");

endmodule

// ===== design/vsi_datapath.sv =====
// Datapath of the vector stroke interpolator: stroke state, distance and
// segment count, serial divider, incremental line walk and output register.
// Depends on vsi_pkg; commanded by vsi_ctrl.
module vsi_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  vsi_pkg::vsi_cmd_t             cmd,
  output vsi_pkg::vsi_status_t          st,
  input  logic                          cfg_write,
  input  logic [vsi_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [vsi_pkg::CFG_W-1:0]     cfg_data,
  input  logic signed [vsi_pkg::COORD_W-1:0] point_x,
  input  logic signed [vsi_pkg::COORD_W-1:0] point_y,
  input  logic                          pen_down,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vsi_pkg::LEVEL_W-1:0]   level_x,
  output logic [vsi_pkg::LEVEL_W-1:0]   level_y,
  output logic                          beam_on,
  output logic                          last_of_run
);
  import vsi_pkg::*;

  logic inv_h;
  logic inv_v;

  logic signed [COORD_W-1:0] prev_x, prev_y;
  logic                      prev_pen;
  logic signed [COORD_W-1:0] start_x, start_y;
  logic                      draw_mode;
  logic                      beam;

  logic signed [Q_W-1:0]     dx, dy;
  logic [MAG_W-1:0]          mag_x, mag_y;
  logic [2*MAG_W-1:0]        sq_x, sq_y;
  logic [SEG_W-1:0]          segs;

  logic [MAG_W-1:0]          div_qx, div_qy;
  logic [SEG_W-1:0]          div_rx, div_ry;
  logic [DCNT_W-1:0]         div_cnt;

  logic signed [Q_W-1:0]     qd_x, qd_y;
  logic [SEG_W-1:0]          rd_x, rd_y;
  logic signed [Q_W-1:0]     q_x, q_y;
  logic [SEG_W-1:0]          r_x, r_y;
  logic [SEG_W-1:0]          idx;

  logic signed [Q_W-1:0]     pt_x, pt_y;

  // One restoring step: returns {remainder, quotient bit}.
  function automatic logic [SEG_W:0] div_bit(input logic [SEG_W-1:0] rem,
                                             input logic nb,
                                             input logic [SEG_W-1:0] s);
    logic [SEG_W:0] sh;
    sh = {rem, nb};
    if (sh >= {1'b0, s}) return {SEG_W'(sh - {1'b0, s}), 1'b1};
    return {sh[SEG_W-1:0], 1'b0};
  endfunction

  // Floor quotient from magnitude division and the sign of the dividend.
  function automatic logic signed [Q_W-1:0] floor_q(input logic [MAG_W-1:0] qa,
                                                    input logic [SEG_W-1:0] ra,
                                                    input logic neg);
    logic [Q_W-1:0] qe;
    qe = {1'b0, qa};
    if (!neg) return $signed(qe);
    if (ra != '0) return $signed(~qe);
    return $signed(-qe);
  endfunction

  function automatic logic [SEG_W-1:0] floor_r(input logic [SEG_W-1:0] ra,
                                               input logic neg,
                                               input logic [SEG_W-1:0] s);
    if (neg && ra != '0) return s - ra;
    return ra;
  endfunction

  // Walk position rounded toward zero from its floor and remainder.
  function automatic logic signed [Q_W-1:0] trunc_pos(input logic signed [Q_W-1:0] q,
                                                      input logic [SEG_W-1:0] r);
    if (q < 0 && r != '0) return q + Q_W'(1);
    return q;
  endfunction

  assign mag_x = dx[Q_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
  assign mag_y = dy[Q_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];

  assign pt_x = trunc_pos(q_x, r_x);
  assign pt_y = trunc_pos(q_y, r_y);

  assign st.draw      = pen_down && prev_pen;
  assign st.div_last  = (div_cnt == DCNT_W'(MAG_W - 1));
  assign st.emit_last = !draw_mode || (idx == segs);
  assign st.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_h <= 1'b1;
      inv_v <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INV_H: inv_h <= cfg_data[0];
        REG_INV_V: inv_v <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stroke state and control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_y    <= '0;
      prev_pen  <= 1'b0;
      draw_mode <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        prev_x    <= point_x;
        prev_y    <= point_y;
        prev_pen  <= pen_down;
        draw_mode <= st.draw;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Arithmetic pipeline and line walk.
  always_ff @(posedge clk) begin
    logic [SEG_W:0] bx, by;
    logic [SEG_W:0] sx, sy;
    if (cmd.accept) begin
      start_x <= prev_x;
      start_y <= prev_y;
      beam    <= pen_down;
      q_x     <= Q_W'(point_x);
      q_y     <= Q_W'(point_y);
      r_x     <= '0;
      r_y     <= '0;
      idx     <= '0;
    end
    if (cmd.diff) begin
      dx <= Q_W'(prev_x) - Q_W'(start_x);
      dy <= Q_W'(prev_y) - Q_W'(start_y);
    end
    if (cmd.square) begin
      sq_x <= mag_x * mag_x;
      sq_y <= mag_y * mag_y;
    end
    if (cmd.segs) begin
      segs    <= seg_count(D2_W'(sq_x) + D2_W'(sq_y));
      div_qx  <= mag_x;
      div_qy  <= mag_y;
      div_rx  <= '0;
      div_ry  <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      bx = div_bit(div_rx, div_qx[MAG_W-1], segs);
      by = div_bit(div_ry, div_qy[MAG_W-1], segs);
      div_rx  <= bx[SEG_W:1];
      div_ry  <= by[SEG_W:1];
      div_qx  <= {div_qx[MAG_W-2:0], bx[0]};
      div_qy  <= {div_qy[MAG_W-2:0], by[0]};
      div_cnt <= div_cnt + DCNT_W'(1);
    end
    if (cmd.fixup) begin
      qd_x <= floor_q(div_qx, div_rx, dx[Q_W-1]);
      qd_y <= floor_q(div_qy, div_ry, dy[Q_W-1]);
      rd_x <= floor_r(div_rx, dx[Q_W-1], segs);
      rd_y <= floor_r(div_ry, dy[Q_W-1], segs);
      q_x  <= Q_W'(start_x);
      q_y  <= Q_W'(start_y);
      r_x  <= '0;
      r_y  <= '0;
      idx  <= '0;
    end
    if (cmd.emit) begin
      level_x     <= to_level(pt_x, inv_h);
      level_y     <= to_level(pt_y, inv_v);
      beam_on     <= beam;
      last_of_run <= st.emit_last;
      // Advance by delta/segs: the remainder stays below segs with one correction.
      sx = {1'b0, r_x} + {1'b0, rd_x};
      sy = {1'b0, r_y} + {1'b0, rd_y};
      if (sx >= {1'b0, segs}) begin
        r_x <= SEG_W'(sx - {1'b0, segs});
        q_x <= q_x + qd_x + Q_W'(1);
      end else begin
        r_x <= sx[SEG_W-1:0];
        q_x <= q_x + qd_x;
      end
      if (sy >= {1'b0, segs}) begin
        r_y <= SEG_W'(sy - {1'b0, segs});
        q_y <= q_y + qd_y + Q_W'(1);
      end else begin
        r_y <= sy[SEG_W-1:0];
        q_y <= q_y + qd_y;
      end
      idx <= idx + SEG_W'(1);
    end
  end

  a_segs_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && draw_mode) |-> (segs >= SEG_W'(1) && segs <= SEG_W'(MAX_SEGMENTS)))
    else $error("segment count out of range while drawing");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && draw_mode) |-> (r_x < segs && r_y < segs))
    else $error("walk remainder not below the segment count");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && draw_mode) |-> (idx <= segs))
    else $error("line walk ran past its last point");

endmodule

// ===== design/vector_stroke_interpolator_top.sv =====
// Channel    Direction  Handshake             Payload
// stroke in  input      in_valid / in_stall   point_x, point_y, pen_down
// DAC out    output     out_valid / out_stall level_x, level_y, beam_on, last_of_run
// config     input      cfg_write             cfg_index, cfg_data
//
// A pen-up item, or the first pen-down item of a stroke, is accepted and then emitted.
// A line item of S segments (up to 8) runs difference, square, segment count, the
// serial divider (one quotient bit per cycle), set-up, then S + 1 points, one per
// cycle while the output register has room.
// Output stalls hold the walk; the input is stalled whenever an item is in progress.
// Synchronous reset clears the stroke state and sets horizontal inversion.
// Top level of the vector stroke interpolator; depends on vsi_pkg, vsi_ctrl, vsi_datapath.
module vector_stroke_interpolator_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [vsi_pkg::COORD_W-1:0] point_x,
  input  logic signed [vsi_pkg::COORD_W-1:0] point_y,
  input  logic                               pen_down,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [vsi_pkg::LEVEL_W-1:0]        level_x,
  output logic [vsi_pkg::LEVEL_W-1:0]        level_y,
  output logic                               beam_on,
  output logic                               last_of_run,
  input  logic                               cfg_write,
  input  logic [vsi_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [vsi_pkg::CFG_W-1:0]          cfg_data
);
  import vsi_pkg::*;

  vsi_cmd_t    cmd;
  vsi_status_t st;

  vsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  vsi_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_x     (point_x),
    .point_y     (point_y),
    .pen_down    (pen_down),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .level_x     (level_x),
    .level_y     (level_y),
    .beam_on     (beam_on),
    .last_of_run (last_of_run)
  );

endmodule

// ===== dv/tb_vector_stroke_interpolator_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for vector_stroke_interpolator_top: a directed table of stroke points,
// then random strokes under random input gaps, output stalls and inversion settings.
// Depends on vsi_pkg and the design top level only.
module tb_vector_stroke_interpolator_top;
  import vsi_pkg::*;

  localparam int RUN_LIMIT  = 200000;
  localparam int DRAIN_TAIL = 40;
  localparam int PHASE_PTS  = 22;

  typedef struct packed {
    logic [LEVEL_W-1:0] lx;
    logic [LEVEL_W-1:0] ly;
    logic               beam;
    logic               last;
  } dac_point_t;

  typedef struct packed {
    int                        x;
    int                        y;
    logic                      pen;
    logic                      typed;
    dac_point_t                want;
  } stroke_row_t;

  // Literal results hold for the reset setting: horizontal mirrored, vertical straight.
  localparam stroke_row_t DIRECTED_ROWS [21] = '{
    '{0,     0,     1'b0, 1'b1, '{8'd255, 8'd0,   1'b0, 1'b1}},
    '{-1024, -1024, 1'b0, 1'b1, '{8'd255, 8'd0,   1'b0, 1'b1}},
    '{1023,  1023,  1'b0, 1'b1, '{8'd0,   8'd255, 1'b0, 1'b1}},
    '{100,   50,    1'b1, 1'b1, '{8'd155, 8'd50,  1'b1, 1'b1}},
    '{100,   50,    1'b1, 1'b0, '0},
    '{103,   54,    1'b1, 1'b0, '0},
    '{1023,  1023,  1'b1, 1'b0, '0},
    '{-1024, -1024, 1'b1, 1'b0, '0},
    '{-1024, 1023,  1'b1, 1'b0, '0},
    '{1023,  -1024, 1'b1, 1'b0, '0},
    '{-5,    300,   1'b0, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b1}},
    '{-5,    300,   1'b1, 1'b1, '{8'd255, 8'd255, 1'b1, 1'b1}},
    '{20,    280,   1'b1, 1'b0, '0},
    '{17,    283,   1'b1, 1'b0, '0},
    '{-7,    -13,   1'b1, 1'b0, '0},
    '{0,     0,     1'b1, 1'b0, '0},
    '{128,   128,   1'b0, 1'b1, '{8'd127, 8'd128, 1'b0, 1'b1}},
    '{255,   0,     1'b1, 1'b1, '{8'd0,   8'd0,   1'b1, 1'b1}},
    '{0,     255,   1'b1, 1'b0, '0},
    '{1,     -1,    1'b1, 1'b0, '0},
    '{0,     255,   1'b0, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b1}}
  };

  // Bit 1 is the horizontal inversion, bit 0 the vertical one.
  localparam logic [1:0] INVERSION_STEPS [4] = '{2'b00, 2'b11, 2'b01, 2'b10};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic                      pen_down = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [LEVEL_W-1:0]        level_x;
  logic [LEVEL_W-1:0]        level_y;
  logic                      beam_on;
  logic                      last_of_run;
  logic                      cfg_write = 1'b0;
  logic [CIDX_W-1:0]         cfg_index = REG_INV_H;
  logic [CFG_W-1:0]          cfg_data = '0;

  // Predictor state and the expected DAC points still to arrive.
  logic       inv_h = 1'b1;
  logic       inv_v = 1'b0;
  int         prev_x = 0;
  int         prev_y = 0;
  logic       pen_held = 1'b0;
  dac_point_t traced[$];
  dac_point_t awaited[$];

  logic       calm = 1'b0;
  int         stall_left = 0;
  int         cycles = 0;
  int         mismatches = 0;
  int         points_fed = 0;
  int         points_seen = 0;
  int         lines_drawn = 0;
  dac_point_t seen_point;
  dac_point_t due_point;

  vector_stroke_interpolator_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .pen_down    (pen_down),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .level_x     (level_x),
    .level_y     (level_y),
    .beam_on     (beam_on),
    .last_of_run (last_of_run),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [LEVEL_W-1:0] dac_level(input int v, input logic inv);
    logic [LEVEL_W-1:0] c;
    if (v < 0) c = '0;
    else if (v > LEVEL_MAX) c = LEVEL_W'(LEVEL_MAX);
    else c = LEVEL_W'(v);
    return inv ? LEVEL_W'(LEVEL_MAX - int'(c)) : c;
  endfunction

  // Fills traced with the DAC points that one stroke point produces.
  task automatic trace_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y, input logic pen);
    int dx;
    int dy;
    int d2;
    int segs;
    traced.delete();
    if (!pen || !pen_held) begin
      traced.push_back(dac_point_t'{dac_level(x, inv_h), dac_level(y, inv_v), pen, 1'b1});
    end else begin
      dx = int'(x) - prev_x;
      dy = int'(y) - prev_y;
      d2 = dx * dx + dy * dy;
      segs = MAX_SEGMENTS;
      while (segs > 1 && STEP_SQ * segs * segs > d2) segs--;
      // Integer division truncates towards zero, as the line walk requires.
      for (int i = 0; i <= segs; i++) begin
        traced.push_back(dac_point_t'{dac_level((prev_x * segs + i * dx) / segs, inv_h),
                                      dac_level((prev_y * segs + i * dy) / segs, inv_v),
                                      1'b1, i == segs});
      end
      lines_drawn++;
    end
    prev_x = x;
    prev_y = y;
    pen_held = pen;
  endtask

  task automatic offer_point(input int x, input int y, input logic pen, input logic typed,
                             input dac_point_t want);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x  <= COORD_W'(x);
    point_y  <= COORD_W'(y);
    pen_down <= pen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trace_point(COORD_W'(x), COORD_W'(y), pen);
    if (typed) awaited.push_back(want);
    else foreach (traced[i]) awaited.push_back(traced[i]);
    points_fed++;
  endtask

  // Holds the input back until every outstanding DAC point has been seen.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_inversion(input logic h, input logic v);
    cfg_write <= 1'b1;
    cfg_index <= REG_INV_H;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_INV_V;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    inv_h = h;
    inv_v = v;
  endtask

  function automatic int pick_coord();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 2047)) - 1024;
    return int'($urandom_range(0, 340)) - 40;
  endfunction

  function automatic int nudge(input int c, input int span);
    int n;
    n = c + int'($urandom_range(0, 2 * span)) - span;
    if (n < -1024) n = -1024;
    if (n > 1023) n = 1023;
    return n;
  endfunction

  // Mostly whole strokes (a move, a first pen-down point, then a few line points),
  // with the odd stray point of random pen state thrown in.
  task automatic draw_random(input int count);
    int sent;
    int cx;
    int cy;
    int span;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        cx = pick_coord();
        cy = pick_coord();
        offer_point(cx, cy, 1'b0, 1'b0, '0);
        cx = nudge(cx, 8);
        cy = nudge(cy, 8);
        offer_point(cx, cy, 1'b1, 1'b0, '0);
        sent += 2;
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 3))
            0: span = 3;
            1: span = 20;
            2: span = 60;
            default: span = 400;
          endcase
          cx = nudge(cx, span);
          cy = nudge(cy, span);
          offer_point(cx, cy, 1'b1, 1'b0, '0);
          sent++;
          if ($urandom_range(0, 15) == 0) settle();
        end
      end else begin
        offer_point(int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
                    1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic log_mismatch(input string what, input dac_point_t want, input dac_point_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display({"Mismatch %0d at cycle %0d (%s): expected x=%0d y=%0d beam=%b last=%b,",
                " got x=%0d y=%0d beam=%b last=%b"},
               mismatches, cycles, what, want.lx, want.ly, want.beam, want.last,
               got.lx, got.ly, got.beam, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_point = '{level_x, level_y, beam_on, last_of_run};
      points_seen++;
      if (awaited.size() == 0) begin
        log_mismatch("unexpected point", '0, seen_point);
      end else begin
        due_point = awaited.pop_front();
        if (seen_point.lx !== due_point.lx) log_mismatch("level_x", due_point, seen_point);
        else if (seen_point.ly !== due_point.ly) log_mismatch("level_y", due_point, seen_point);
        else if (seen_point.beam !== due_point.beam) log_mismatch("beam_on", due_point, seen_point);
        else if (seen_point.last !== due_point.last) log_mismatch("last_of_run", due_point, seen_point);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Timed out with %0d DAC points outstanding", awaited.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[r]) begin
      offer_point(DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].y, DIRECTED_ROWS[r].pen,
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end
    settle();

    for (int p = 0; p < 4; p++) begin
      set_inversion(INVERSION_STEPS[p][1], INVERSION_STEPS[p][0]);
      // The last setting runs with neither side idling.
      if (p == 3) calm = 1'b1;
      draw_random(PHASE_PTS);
      settle();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    mismatches += awaited.size();
    $display("Fed %0d stroke points (%0d of them drawn as lines) and checked %0d DAC points",
             points_fed, lines_drawn, points_seen);
    $display("across the reset setting and all four inversion combinations.");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
